[hdl/gravity_tilt_angle_top_assert.svh]
// assertion macros for the tilt angle block
`ifndef GRAVITY_TILT_ANGLE_TOP_ASSERT_SVH
`define GRAVITY_TILT_ANGLE_TOP_ASSERT_SVH

// same-cycle implication
`define GTA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gta_pkg.sv]
package gta_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int MAX_STAGES        = 24;
  localparam int SENSOR_COUNT      = 6;
  localparam int MASK_W            = 6;
  localparam int POS_W             = 3;
  localparam int G_W               = 16;
  localparam int ANG_W             = 15;
  localparam int XY_W              = 27;
  localparam int Z_W               = 27;
  localparam int RND_SH            = 10;
  localparam int RND_W             = Z_W - RND_SH;
  localparam int SUM_W             = RND_W + 1;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 8;

  localparam int HALF_TURN = 11520;
  localparam int FULL_TURN = 23040;
  localparam int Z_HALF    = 180 * 65536;
  localparam int RND_BIAS  = 512;

  localparam logic [CFG_IDX_W-1:0] REG_MIRROR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = CFG_IDX_W'(1);

  localparam logic [MASK_W-1:0] MIRROR_RST = MASK_W'(5);
  localparam logic [MASK_W-1:0] SWAP_RST   = MASK_W'(32);

  localparam logic signed [ANG_W-1:0] ANG_MAX = ANG_W'(HALF_TURN);
  localparam logic signed [ANG_W-1:0] ANG_MIN = ANG_W'(1 - HALF_TURN);

  typedef struct packed {
    logic [POS_W-1:0]       pos;
    logic                   swapped;
    logic                   mirrored;
    logic                   zero;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } cordic_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_at(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/gta_ifs.sv]
interface gta_in_if;
  logic                           valid;
  logic                           ready;
  logic [gta_pkg::POS_W-1:0]      position;
  logic signed [gta_pkg::G_W-1:0] gravity_x;
  logic signed [gta_pkg::G_W-1:0] gravity_y;
  modport source (output valid, position, gravity_x, gravity_y, input ready);
  modport sink (input valid, position, gravity_x, gravity_y, output ready);
endinterface

interface gta_out_if;
  logic                             valid;
  logic                             ready;
  logic [gta_pkg::POS_W-1:0]        position_out;
  logic signed [gta_pkg::ANG_W-1:0] angle;
  modport source (output valid, position_out, angle, input ready);
  modport sink (input valid, position_out, angle, output ready);
endinterface

interface gta_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [gta_pkg::CFG_IDX_W-1:0]    index;
  logic [gta_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hdl/gravity_tilt_angle_top.sv]
// Tilt angle from one gravity sample (X, Y in signed Q8.8) and a sensor position,
// returned in 1/64 degree in (-180, 180] through a pipelined CORDIC atan2. The
// block takes one sample per clock unless back-pressure stalls it; each sample passes
// one register stage for the input setup, one for each CORDIC iteration and two
// for rounding and angle wrap. Back-pressure on the result channel only fills
// empty pipeline slots before input ready drops. The user must write the mirror and
// swap masks through the configuration channel only while no sample is in flight;
// the block does not enforce this. cfg ready is always high.
`include "gravity_tilt_angle_top_assert.svh"

module gravity_tilt_angle_top #(
  parameter int CORDIC_STAGES = gta_pkg::CORDIC_STAGES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  gta_in_if.sink    in_if,
  gta_out_if.source out_if,
  gta_cfg_if.sink   cfg_if
);

  logic [gta_pkg::MASK_W-1:0] mirror_r;
  logic [gta_pkg::MASK_W-1:0] swap_r;

  logic             stg_v   [CORDIC_STAGES+1];
  logic             stg_rdy [CORDIC_STAGES+1];
  gta_pkg::cordic_t stg_d   [CORDIC_STAGES+1];

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mirror_r <= gta_pkg::MIRROR_RST;
      swap_r   <= gta_pkg::SWAP_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        gta_pkg::REG_MIRROR: mirror_r <= cfg_if.data[gta_pkg::MASK_W-1:0];
        gta_pkg::REG_SWAP:   swap_r   <= cfg_if.data[gta_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gta_pre u_pre (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .mirror_mask (mirror_r),
    .swap_mask   (swap_r),
    .dout_valid  (stg_v[0]),
    .dout_ready  (stg_rdy[0]),
    .dout        (stg_d[0])
  );

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
    gta_stage #(
      .IDX (k)
    ) u_stage (
      .clk        (clk),
      .rst_n      (rst_n),
      .din_valid  (stg_v[k]),
      .din_ready  (stg_rdy[k]),
      .din        (stg_d[k]),
      .dout_valid (stg_v[k+1]),
      .dout_ready (stg_rdy[k+1]),
      .dout       (stg_d[k+1])
    );
  end

  gta_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .din_valid (stg_v[CORDIC_STAGES]),
    .din_ready (stg_rdy[CORDIC_STAGES]),
    .din       (stg_d[CORDIC_STAGES]),
    .out_if    (out_if)
  );

  `GTA_ASSERT_NOW(a_angle_range, out_if.valid,
    (out_if.angle <= gta_pkg::ANG_MAX) && (out_if.angle >= gta_pkg::ANG_MIN),
    "angle out of range")
  `GTA_ASSERT_NOW(a_empty_accepts, !out_if.valid, in_if.ready,
    "input stalled with empty output")
  `GTA_ASSERT_NEXT(a_mirror_write,
    cfg_if.valid && cfg_if.ready && (cfg_if.index == gta_pkg::REG_MIRROR),
    mirror_r == $past(cfg_if.data[gta_pkg::MASK_W-1:0]), "mirror mask not written")

endmodule

[hdl/gta_pre.sv]
module gta_pre (
  input  logic                         clk,
  input  logic                         rst_n,
  gta_in_if.sink                       in_if,
  input  logic [gta_pkg::MASK_W-1:0]   mirror_mask,
  input  logic [gta_pkg::MASK_W-1:0]   swap_mask,
  output logic                         dout_valid,
  input  logic                         dout_ready,
  output gta_pkg::cordic_t             dout
);

  logic                                 v_r;
  gta_pkg::cordic_t                     d_r;
  gta_pkg::cordic_t                     d_nxt;
  logic                                 ready;
  logic                                 in_rng;
  logic signed [gta_pkg::G_W-1:0]       n;
  logic signed [gta_pkg::G_W-1:0]       d;
  logic signed [gta_pkg::XY_W-1:0]      xs;
  logic signed [gta_pkg::XY_W-1:0]      ys;

  assign ready       = !v_r || dout_ready;
  assign in_if.ready = ready;
  assign dout_valid  = v_r;
  assign dout        = d_r;

  always_comb begin
    in_rng = (int'(in_if.position) < gta_pkg::SENSOR_COUNT) &&
             (int'(in_if.position) < gta_pkg::MASK_W);
    d_nxt.pos      = in_if.position;
    d_nxt.swapped  = in_rng && swap_mask[in_if.position];
    d_nxt.mirrored = in_rng && mirror_mask[in_if.position];
    n  = d_nxt.swapped ? in_if.gravity_y : in_if.gravity_x;
    d  = d_nxt.swapped ? in_if.gravity_x : in_if.gravity_y;
    d_nxt.zero = (n == '0) && (d == '0);
    xs = gta_pkg::XY_W'(d) <<< 8;
    ys = gta_pkg::XY_W'(n) <<< 8;
    // left half plane: turn by a half turn first
    if (d < 0) begin
      d_nxt.x = -xs;
      d_nxt.y = -ys;
      d_nxt.z = (n >= 0) ? gta_pkg::Z_W'(gta_pkg::Z_HALF) : -gta_pkg::Z_W'(gta_pkg::Z_HALF);
    end else begin
      d_nxt.x = xs;
      d_nxt.y = ys;
      d_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ready) begin
      v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_if.valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

[hdl/gta_stage.sv]
module gta_stage #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             din_valid,
  output logic             din_ready,
  input  gta_pkg::cordic_t din,
  output logic             dout_valid,
  input  logic             dout_ready,
  output gta_pkg::cordic_t dout
);

  localparam logic signed [gta_pkg::Z_W-1:0] ATAN = gta_pkg::atan_at(IDX);

  logic                            v_r;
  gta_pkg::cordic_t                d_r;
  gta_pkg::cordic_t                d_nxt;
  logic signed [gta_pkg::XY_W-1:0] xs;
  logic signed [gta_pkg::XY_W-1:0] ys;

  assign din_ready  = !v_r || dout_ready;
  assign dout_valid = v_r;
  assign dout       = d_r;

  always_comb begin
    d_nxt = din;
    xs    = din.x >>> IDX;
    ys    = din.y >>> IDX;
    if (din.y >= 0) begin
      d_nxt.x = din.x + ys;
      d_nxt.y = din.y - xs;
      d_nxt.z = din.z + ATAN;
    end else begin
      d_nxt.x = din.x - ys;
      d_nxt.y = din.y + xs;
      d_nxt.z = din.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (din_ready) begin
      v_r <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din_ready && din_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

[hdl/gta_post.sv]
module gta_post (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             din_valid,
  output logic             din_ready,
  input  gta_pkg::cordic_t din,
  gta_out_if.source        out_if
);

  localparam logic signed [gta_pkg::SUM_W-1:0] HALF_S = gta_pkg::SUM_W'(gta_pkg::HALF_TURN);
  localparam logic signed [gta_pkg::SUM_W-1:0] FULL_S = gta_pkg::SUM_W'(gta_pkg::FULL_TURN);

  logic                             va_r;
  logic [gta_pkg::POS_W-1:0]        posa_r;
  logic                             mira_r;
  logic signed [gta_pkg::SUM_W-1:0] a_r;
  logic signed [gta_pkg::SUM_W-1:0] a_nxt;
  logic                             vb_r;
  logic [gta_pkg::POS_W-1:0]        posb_r;
  logic signed [gta_pkg::ANG_W-1:0] angb_r;
  logic signed [gta_pkg::ANG_W-1:0] angb_nxt;
  logic                             ready_a;
  logic                             ready_b;
  logic signed [gta_pkg::Z_W-1:0]   zsum;
  logic signed [gta_pkg::RND_W-1:0] rnd;
  logic                             wrap_hi;
  logic                             wrap_lo;
  logic                             at_half;
  logic signed [gta_pkg::SUM_W-1:0] w;

  assign ready_b   = !vb_r || out_if.ready;
  assign ready_a   = !va_r || ready_b;
  assign din_ready = ready_a;

  assign out_if.valid        = vb_r;
  assign out_if.position_out = posb_r;
  assign out_if.angle        = angb_r;

  // round to 1/64 degree and add the half turn, negating the sum for swapped samples
  always_comb begin
    zsum  = din.z + gta_pkg::Z_W'(gta_pkg::RND_BIAS);
    rnd   = din.zero ? '0 : zsum[gta_pkg::Z_W-1:gta_pkg::RND_SH];
    a_nxt = din.swapped ? (-HALF_S - gta_pkg::SUM_W'(rnd)) : (gta_pkg::SUM_W'(rnd) + HALF_S);
  end

  // wrap, then mirror and wrap again, all candidates in parallel
  always_comb begin
    wrap_hi = a_r > HALF_S;
    wrap_lo = a_r <= -HALF_S;
    at_half = (a_r == HALF_S) || (a_r == -HALF_S);
    if (mira_r) begin
      if (at_half) begin
        w = HALF_S;
      end else if (wrap_hi) begin
        w = FULL_S - a_r;
      end else if (wrap_lo) begin
        w = -FULL_S - a_r;
      end else begin
        w = -a_r;
      end
    end else begin
      if (wrap_hi) begin
        w = a_r - FULL_S;
      end else if (wrap_lo) begin
        w = a_r + FULL_S;
      end else begin
        w = a_r;
      end
    end
    angb_nxt = w[gta_pkg::ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (ready_a) begin
        va_r <= din_valid;
      end
      if (ready_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && din_valid) begin
      posa_r <= din.pos;
      mira_r <= din.mirrored;
      a_r    <= a_nxt;
    end
    if (ready_b && va_r) begin
      posb_r <= posa_r;
      angb_r <= angb_nxt;
    end
  end

endmodule

[test/gravity_tilt_angle_top_tb.sv]
`timescale 1ns / 100ps

module gravity_tilt_angle_top_tb;

  localparam int STAGES      = gta_pkg::CORDIC_STAGES_DEF;
  localparam int DRAIN_WAIT  = STAGES + 3 + 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 94;
  localparam int NUM_PHASES  = 8;

  typedef struct packed {
    logic [gta_pkg::POS_W-1:0]       pos;
    logic signed [gta_pkg::G_W-1:0]  gx;
    logic signed [gta_pkg::G_W-1:0]  gy;
  } sample_t;

  typedef struct packed {
    logic [gta_pkg::POS_W-1:0]        pos;
    logic signed [gta_pkg::ANG_W-1:0] angle;
  } tilt_result_t;

  typedef struct packed {
    logic [gta_pkg::CFG_IDX_W-1:0]  idx;
    logic [gta_pkg::CFG_DATA_W-1:0] data;
  } mask_write_t;

  logic clk = 1'b0;
  logic rst_n;

  gta_in_if  in_if();
  gta_out_if out_if();
  gta_cfg_if cfg_if();

  gravity_tilt_angle_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // atan(2^-i) in 2^-16 degree
  longint atan_step [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  logic [gta_pkg::MASK_W-1:0] mirror_bits = gta_pkg::MIRROR_RST;
  logic [gta_pkg::MASK_W-1:0] swap_bits   = gta_pkg::SWAP_RST;

  sample_t      pending_samples[$];
  mask_write_t  pending_mask_writes[$];
  tilt_result_t expected_angles[$];

  sample_t      next_sample;
  mask_write_t  next_write;
  tilt_result_t oldest_angle;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt   = 0;
  int cycle_cnt      = 0;

  // atan2(n, d) in 1/64 degree
  function automatic longint cordic_deg64(longint n, longint d);
    longint x, y, z, xs, ys;
    x = d * 256;
    y = n * 256;
    z = 0;
    if (n == 0 && d == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(gta_pkg::Z_HALF) : -longint'(gta_pkg::Z_HALF);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + atan_step[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - atan_step[i];
      end
    end
    return (z + gta_pkg::RND_BIAS) >>> gta_pkg::RND_SH;
  endfunction

  function automatic longint wrap_turn(longint a);
    if (a > gta_pkg::HALF_TURN) a = a - gta_pkg::FULL_TURN;
    if (a <= -gta_pkg::HALF_TURN) a = a + gta_pkg::FULL_TURN;
    return a;
  endfunction

  function automatic tilt_result_t predict_tilt(sample_t s);
    tilt_result_t r;
    logic         known, swp, mir;
    longint       a;
    known = (s.pos < gta_pkg::SENSOR_COUNT) && (s.pos < gta_pkg::MASK_W);
    swp = known && swap_bits[s.pos];
    mir = known && mirror_bits[s.pos];
    if (swp) a = -(cordic_deg64(longint'(s.gy), longint'(s.gx)) + gta_pkg::HALF_TURN);
    else a = cordic_deg64(longint'(s.gx), longint'(s.gy)) + gta_pkg::HALF_TURN;
    a = wrap_turn(a);
    if (mir) a = wrap_turn(-a);
    r.pos = s.pos;
    r.angle = gta_pkg::ANG_W'(a);
    return r;
  endfunction

  function automatic logic signed [gta_pkg::G_W-1:0] edge_value();
    case ($urandom_range(5))
      0:       return gta_pkg::G_W'(-32768);
      1:       return gta_pkg::G_W'(-32767);
      2:       return gta_pkg::G_W'(-1);
      3:       return gta_pkg::G_W'(0);
      4:       return gta_pkg::G_W'(1);
      default: return gta_pkg::G_W'(32767);
    endcase
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      v;
    if ($urandom_range(9) == 0) s.pos = gta_pkg::POS_W'($urandom_range(7, 6));
    else s.pos = gta_pkg::POS_W'($urandom_range(5));
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        s.gx = gta_pkg::G_W'($urandom);
        s.gy = gta_pkg::G_W'($urandom);
      end
      4, 5: begin
        s.gx = gta_pkg::G_W'(int'($urandom_range(5120)) - 2560);
        s.gy = gta_pkg::G_W'(int'($urandom_range(5120)) - 2560);
      end
      6: begin
        s.gx = gta_pkg::G_W'($urandom);
        s.gy = gta_pkg::G_W'($urandom);
        if ($urandom_range(1)) s.gx = '0;
        else s.gy = '0;
      end
      7: begin
        s.gx = gta_pkg::G_W'(int'($urandom_range(8)) - 4);
        s.gy = gta_pkg::G_W'(int'($urandom_range(8)) - 4);
      end
      8: begin
        s.gx = edge_value();
        s.gy = edge_value();
      end
      default: begin
        v = int'($urandom_range(65535)) - 32768;
        s.gx = gta_pkg::G_W'(v);
        s.gy = $urandom_range(1) ? gta_pkg::G_W'(v) : gta_pkg::G_W'(-v);
      end
    endcase
    return s;
  endfunction

  task automatic push_sample(int p, int x, int y);
    sample_t s;
    s.pos = gta_pkg::POS_W'(p);
    s.gx = gta_pkg::G_W'(x);
    s.gy = gta_pkg::G_W'(y);
    pending_samples.push_back(s);
  endtask

  task automatic push_mask_write(logic [gta_pkg::CFG_IDX_W-1:0] idx,
                                 logic [gta_pkg::MASK_W-1:0] bits);
    mask_write_t w;
    w.idx = idx;
    w.data = {2'($urandom), bits};
    pending_mask_writes.push_back(w);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || pending_mask_writes.size() != 0 ||
           in_if.valid || cfg_if.valid || expected_angles.size() != 0);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    if (mismatch_cnt < 50)
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_cnt);
    mismatch_cnt++;
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_if.ready) begin
      if (in_if.valid) begin
        next_sample.pos = in_if.position;
        next_sample.gx = in_if.gravity_x;
        next_sample.gy = in_if.gravity_y;
        expected_angles.push_back(predict_tilt(next_sample));
      end
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_sample = pending_samples.pop_front();
        in_if.valid <= 1'b1;
        in_if.position <= next_sample.pos;
        in_if.gravity_x <= next_sample.gx;
        in_if.gravity_y <= next_sample.gy;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // mask register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_if.valid <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == gta_pkg::REG_MIRROR)
          mirror_bits <= cfg_if.data[gta_pkg::MASK_W-1:0];
        else if (cfg_if.index == gta_pkg::REG_SWAP)
          swap_bits <= cfg_if.data[gta_pkg::MASK_W-1:0];
      end
      if (!cfg_if.valid || cfg_if.ready) begin
        if (pending_mask_writes.size() != 0) begin
          next_write = pending_mask_writes.pop_front();
          cfg_if.valid <= 1'b1;
          cfg_if.index <= next_write.idx;
          cfg_if.data <= next_write.data;
        end else begin
          cfg_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b1;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_angles.size() == 0) begin
          report_mismatch("unexpected transaction", out_if.angle, 0);
        end else begin
          oldest_angle = expected_angles.pop_front();
          if (out_if.position_out !== oldest_angle.pos)
            report_mismatch("position_out", out_if.position_out, oldest_angle.pos);
          if (out_if.angle !== oldest_angle.angle)
            report_mismatch("angle", out_if.angle, oldest_angle.angle);
        end
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [gta_pkg::MASK_W-1:0] mir_set, swp_set;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.position = '0;
    in_if.gravity_x = '0;
    in_if.gravity_y = '0;
    out_if.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed transactions with the reset masks
    @(negedge clk);
    for (int p = 0; p < gta_pkg::SENSOR_COUNT; p++) push_sample(p, 0, 0);
    push_sample(0, 32767, 32767);
    push_sample(1, -32768, -32768);
    push_sample(2, 32767, -32768);
    push_sample(3, -32768, 32767);
    push_sample(4, 0, -256);
    push_sample(4, 0, 256);
    push_sample(1, 256, 0);
    push_sample(1, -256, 0);
    push_sample(5, 256, 0);
    push_sample(5, -256, 0);
    push_sample(5, 0, -32768);
    push_sample(6, 100, -100);
    push_sample(7, -1, 1);
    push_sample(0, 1, -1);
    wait_idle();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          mir_set = '0;
          swp_set = '0;
        end
        1: begin
          mir_set = '1;
          swp_set = '1;
        end
        2: begin
          mir_set = gta_pkg::MASK_W'(6'h2a);
          swp_set = gta_pkg::MASK_W'(6'h15);
        end
        3: begin
          mir_set = '1;
          swp_set = '0;
        end
        4: begin
          mir_set = '0;
          swp_set = '1;
        end
        default: begin
          mir_set = gta_pkg::MASK_W'($urandom);
          swp_set = gta_pkg::MASK_W'($urandom);
        end
      endcase
      push_mask_write(gta_pkg::REG_MIRROR, mir_set);
      push_mask_write(gta_pkg::REG_SWAP, swp_set);
      push_mask_write(gta_pkg::CFG_IDX_W'($urandom_range(3, 2)),
                      gta_pkg::MASK_W'($urandom));
      wait_idle();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) pending_samples.push_back(random_sample());
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
